### rtl/sactl_pkg.sv
// Shared constants, codes and types for the cache tag and replacement controller.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package sactl_pkg;

  // Fixed field widths of the access and result beats.
  localparam int ADDR_W     = 24;
  localparam int TAG_W      = 24;
  localparam int OUT_WAY_W  = 2;
  localparam int OUT_SET_W  = 6;

  // Configuration register widths and port widths.
  localparam int OFF_W      = 4;
  localparam int IB_W       = 3;
  localparam int NW_W       = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  // Default build parameters.
  localparam int WAYS_DEF     = 4;
  localparam int SET_BITS_DEF = 6;
  localparam int AGE_BITS_DEF = 16;

  // Depth of the queue between the front and the back.
  localparam int Q_DEPTH = 2;

  // Configuration register reset values.
  localparam logic [OFF_W-1:0] OFF_RST = 4'd6;
  localparam logic [IB_W-1:0]  IB_RST  = 3'd6;
  localparam logic [NW_W-1:0]  NW_RST  = 3'd4;

  // Access command code for a load; the other code is a store.
  localparam logic CMD_LOAD = 1'b0;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_OFFSET = 2'd0,
    CFG_INDEX_BITS   = 2'd1,
    CFG_WAYS_IN_USE  = 2'd2
  } sactl_cfg_idx_t;

  // Current configuration, fanned out to the front and the back.
  typedef struct packed {
    logic [OFF_W-1:0] block_offset_bits;
    logic [IB_W-1:0]  index_bits;
    logic [NW_W-1:0]  ways_in_use;
  } sactl_cfg_t;

  // Status of the back part.
  typedef struct packed {
    logic clearing;
    logic pop;
  } sactl_bstat_t;

endpackage

### rtl/sactl_req_if.sv
// Access request channel: valid/ready handshake with command and address.
// Depends on sactl_pkg for the address width.
`timescale 1ns / 1ps

interface sactl_req_if import sactl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output command, output address, input ready);
  modport sink   (input valid, input command, input address, output ready);
endinterface

### rtl/sactl_rsp_if.sv
// Result channel: valid/ready handshake with hit, way, filled and set index.
// Depends on sactl_pkg for the field widths.
`timescale 1ns / 1ps

interface sactl_rsp_if import sactl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [OUT_WAY_W-1:0] way;
  logic                 filled;
  logic [OUT_SET_W-1:0] set_index;

  modport source (output valid, output hit, output way, output filled, output set_index,
                  input ready);
  modport sink   (input valid, input hit, input way, input filled, input set_index,
                  output ready);
endinterface

### rtl/sactl_cfg_if.sv
// Configuration write channel: valid/ready handshake with register index and data.
// Depends on sactl_pkg for the index and data widths.
`timescale 1ns / 1ps

interface sactl_cfg_if import sactl_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/set_assoc_cache_tag_lru.sv
// Top level of the cache tag and replacement controller: configuration registers,
// front part, queue and back part. Depends on sactl_pkg, the three channel interfaces,
// sactl_front, sactl_queue and sactl_back.
`timescale 1ns / 1ps

// Tag and LRU-age controller of a WAYS-way set-associative, write-through,
// no-write-allocate cache on 24-bit addresses. Each access beat yields exactly one
// result beat, in order. After reset the tag store (one row per set) is cleared in a
// pass over all 2^SET_BITS rows (64 with the defaults) during which no access is taken;
// configuration writes are taken at any time and should be made while no access is
// outstanding. An access then passes through the back part in steps that are set by the
// read-modify-write of its set's row in the tag store: row read, aging and tag compare,
// victim choice and write-back. The back part takes no new access until that write-back
// is done and the result register is free; further accesses wait in the two-entry queue
// that sits behind the input port.
module set_assoc_cache_tag_lru import sactl_pkg::*; #(
  parameter int WAYS     = WAYS_DEF,
  parameter int SET_BITS = SET_BITS_DEF,
  parameter int AGE_BITS = AGE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  sactl_req_if.sink   in_ch,
  sactl_rsp_if.source out_ch,
  sactl_cfg_if.sink   cfg_ch
);

  localparam int SET_W  = (SET_BITS > 0) ? SET_BITS : 1;
  localparam int ITEM_W = 1 + TAG_W + SET_W;

  sactl_cfg_t        cfg_r;
  sactl_bstat_t      bstat;
  logic              push_valid;
  logic              push_ready;
  logic [ITEM_W-1:0] push_data;
  logic              pop_valid;
  logic              pop_ready;
  logic [ITEM_W-1:0] pop_data;

  // Configuration registers; writes to unknown indexes are dropped.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.block_offset_bits <= OFF_RST;
      cfg_r.index_bits        <= IB_RST;
      cfg_r.ways_in_use       <= NW_RST;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_ch.index)
        CFG_BLOCK_OFFSET: cfg_r.block_offset_bits <= cfg_ch.data[OFF_W-1:0];
        CFG_INDEX_BITS:   cfg_r.index_bits        <= cfg_ch.data[IB_W-1:0];
        CFG_WAYS_IN_USE:  cfg_r.ways_in_use       <= cfg_ch.data[NW_W-1:0];
        default: ;
      endcase
    end
  end

  // Front part: address split.
  sactl_front #(
    .SET_BITS (SET_BITS)
  ) u_front (
    .in_ch      (in_ch),
    .cfg        (cfg_r),
    .bstat      (bstat),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Queue between the two parts.
  sactl_queue #(
    .DATA_W (ITEM_W)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back part: tag store and replacement.
  sactl_back #(
    .WAYS     (WAYS),
    .SET_BITS (SET_BITS),
    .AGE_BITS (AGE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch),
    .bstat     (bstat)
  );

  // A result beat never reports both a hit and a fill.
  a_hit_excl_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.hit && out_ch.filled))
    else $error("result beat reports both a hit and a fill");

  // No access leaves the queue while the tag store is being cleared.
  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    bstat.clearing |-> !bstat.pop)
    else $error("access taken during the clearing pass");

  // An access taken by the back part shows up as a result after its lookup and fill states.
  a_pop_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    bstat.pop |-> ##3 out_ch.valid)
    else $error("result beat missing after an access was taken");

endmodule

### rtl/sactl_front.sv
// Front part: accepts access beats and splits the address into set index and tag.
// Depends on sactl_pkg and sactl_req_if; feeds the queue in sactl_queue.
`timescale 1ns / 1ps

module sactl_front import sactl_pkg::*; #(
  parameter int SET_BITS = SET_BITS_DEF,
  localparam int SET_W   = (SET_BITS > 0) ? SET_BITS : 1,
  localparam int ITEM_W  = 1 + TAG_W + SET_W
) (
  sactl_req_if.sink         in_ch,
  input  sactl_cfg_t        cfg,
  input  sactl_bstat_t      bstat,
  output logic              push_valid,
  input  logic              push_ready,
  output logic [ITEM_W-1:0] push_data
);

  logic [3:0]        ib_eff;
  logic [4:0]        tag_shift;
  logic [ADDR_W-1:0] addr_sh;
  logic [SET_W-1:0]  set_mask;
  logic [SET_W-1:0]  set_idx;
  logic [TAG_W-1:0]  tag;

  // Index width is limited to the number of sets that are built.
  assign ib_eff = ({1'b0, cfg.index_bits} > 4'(SET_BITS)) ? 4'(SET_BITS)
                                                          : {1'b0, cfg.index_bits};

  // Address split: offset | set index | tag.
  assign addr_sh   = in_ch.address >> cfg.block_offset_bits;
  assign set_mask  = ~({SET_W{1'b1}} << ib_eff);
  assign set_idx   = addr_sh[SET_W-1:0] & set_mask;
  assign tag_shift = 5'(cfg.block_offset_bits) + 5'(ib_eff);
  assign tag       = TAG_W'(in_ch.address >> tag_shift);

  // No beat is taken while the tag store is being cleared.
  assign in_ch.ready = push_ready && !bstat.clearing;
  assign push_valid  = in_ch.valid && !bstat.clearing;
  assign push_data   = {in_ch.command, tag, set_idx};

endmodule

### rtl/sactl_queue.sv
// Two-entry queue that decouples the front part from the back part.
// Depends on sactl_pkg for its depth.
`timescale 1ns / 1ps

module sactl_queue import sactl_pkg::*; #(
  parameter int DATA_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  logic [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output logic [DATA_W-1:0] pop_data
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  logic [DATA_W-1:0] slot_r [Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (cnt_r != CNT_W'(Q_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and fill count update, wrapping at the queue depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Payload storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### rtl/sactl_back.sv
// Back part: tag store, aging, tag compare, fill and victim choice, result register.
// Depends on sactl_pkg and sactl_rsp_if; takes access beats from sactl_queue.
`timescale 1ns / 1ps

module sactl_back import sactl_pkg::*; #(
  parameter int WAYS     = WAYS_DEF,
  parameter int SET_BITS = SET_BITS_DEF,
  parameter int AGE_BITS = AGE_BITS_DEF,
  localparam int SET_W   = (SET_BITS > 0) ? SET_BITS : 1,
  localparam int ITEM_W  = 1 + TAG_W + SET_W
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sactl_cfg_t        cfg,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  logic [ITEM_W-1:0] pop_data,
  sactl_rsp_if.source       out_ch,
  output sactl_bstat_t      bstat
);

  localparam int NSETS = 1 << SET_BITS;
  localparam int ENT_W = 1 + TAG_W + AGE_BITS;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int LVL   = $clog2(WAYS);
  localparam int PW    = 1 << LVL;
  localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_LOOK  = 4'b0100,
    S_FILL  = 4'b1000
  } state_t;

  typedef logic [WAYS-1:0][ENT_W-1:0] row_t;

  state_t state_r, state_nxt;
  logic [SET_W-1:0] clr_cnt_r, clr_cnt_nxt;

  // Tag store: one row per set, each way holds {valid, tag, age}.
  row_t mem [NSETS];
  row_t rd_row_r;
  row_t wr_row;
  logic mem_we;
  logic [SET_W-1:0] mem_wa;
  logic mem_re;

  // Access being worked on.
  logic             cur_cmd_r;
  logic [TAG_W-1:0] cur_tag_r;
  logic [SET_W-1:0] cur_set_r;
  logic             pop_cmd;
  logic [TAG_W-1:0] pop_tag;
  logic [SET_W-1:0] pop_set;

  // Lookup stage results.
  logic [WAYS-1:0][AGE_BITS-1:0] aged, aged_r;
  logic [WAYS-1:0]               match;
  logic [WAYS-1:0]               empty;
  logic [WAYS-1:0]               act;
  logic [4:0]                    nw;
  logic                          hit_n, hit_r;
  logic [WAY_W-1:0]              hit_way_n, hit_way_r;
  logic                          free_n, free_r;
  logic [WAY_W-1:0]              free_way_n, free_way_r;

  // Fill stage signals.
  logic [AGE_BITS-1:0] t_age [LVL+1][PW];
  logic [WAY_W-1:0]    t_idx [LVL+1][PW];
  logic [WAY_W-1:0]    victim;
  logic [WAY_W-1:0]    pick;
  logic                do_fill;
  logic [WAY_W-1:0]    res_way;

  // Result register.
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_hit_r;
  logic [OUT_WAY_W-1:0] out_way_r;
  logic                 out_filled_r;
  logic [OUT_SET_W-1:0] out_set_r;

  assign {pop_cmd, pop_tag, pop_set} = pop_data;

  // Ways in use, clamped to one up to the built number of ways.
  always_comb begin
    if (cfg.ways_in_use == '0) begin
      nw = 5'd1;
    end else if (5'(cfg.ways_in_use) > 5'(WAYS)) begin
      nw = 5'(WAYS);
    end else begin
      nw = 5'(cfg.ways_in_use);
    end
    for (int w = 0; w < WAYS; w++) begin
      act[w] = (5'(w) < nw);
    end
  end

  // A new access is taken only when the result register is free by the next cycle.
  assign pop_ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign mem_re    = pop_valid && pop_ready;

  // Sequencer: clearing pass, then one access at a time through lookup and fill.
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      S_CLEAR: begin
        if (clr_cnt_r == SET_W'(NSETS - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (mem_re) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK:  state_nxt = S_FILL;
      S_FILL:  state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // Capture the access when it leaves the queue.
  always_ff @(posedge clk) begin
    if (mem_re) begin
      cur_cmd_r <= pop_cmd;
      cur_tag_r <= pop_tag;
      cur_set_r <= pop_set;
    end
  end

  // Tag store ports: one write, one registered read.
  assign mem_we = (state_r == S_CLEAR) || (state_r == S_FILL);
  assign mem_wa = (state_r == S_CLEAR) ? clr_cnt_r : cur_set_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= wr_row;
    end
    if (mem_re) begin
      rd_row_r <= mem[pop_set];
    end
  end

  // Lookup: age the valid ways in use, compare tags, find the first free way.
  always_comb begin
    hit_n      = 1'b0;
    hit_way_n  = '0;
    free_n     = 1'b0;
    free_way_n = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (rd_row_r[w][ENT_W-1] && act[w] && (rd_row_r[w][AGE_BITS-1:0] != AGE_MAX)) begin
        aged[w] = rd_row_r[w][AGE_BITS-1:0] + 1'b1;
      end else begin
        aged[w] = rd_row_r[w][AGE_BITS-1:0];
      end
      match[w] = rd_row_r[w][ENT_W-1] && act[w]
                 && (rd_row_r[w][ENT_W-2 -: TAG_W] == cur_tag_r);
      empty[w] = !rd_row_r[w][ENT_W-1] && act[w];
    end
    // Lowest way wins both searches.
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_n     = 1'b1;
        hit_way_n = WAY_W'(w);
      end
      if (empty[w]) begin
        free_n     = 1'b1;
        free_way_n = WAY_W'(w);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_LOOK) begin
      aged_r     <= aged;
      hit_r      <= hit_n;
      hit_way_r  <= hit_way_n;
      free_r     <= free_n;
      free_way_r <= free_way_n;
    end
  end

  // Victim choice: tree of compares for the oldest way in use, lower way on a tie.
  always_comb begin
    for (int l = 0; l <= LVL; l++) begin
      for (int i = 0; i < PW; i++) begin
        t_age[l][i] = '0;
        t_idx[l][i] = '0;
      end
    end
    for (int i = 0; i < WAYS; i++) begin
      t_age[0][i] = act[i] ? aged_r[i] : '0;
      t_idx[0][i] = WAY_W'(i);
    end
    for (int l = 0; l < LVL; l++) begin
      for (int i = 0; i < (PW >> (l + 1)); i++) begin
        if (t_age[l][2*i+1] > t_age[l][2*i]) begin
          t_age[l+1][i] = t_age[l][2*i+1];
          t_idx[l+1][i] = t_idx[l][2*i+1];
        end else begin
          t_age[l+1][i] = t_age[l][2*i];
          t_idx[l+1][i] = t_idx[l][2*i];
        end
      end
    end
  end

  assign victim  = t_idx[LVL][0];
  assign do_fill = !hit_r && (cur_cmd_r == CMD_LOAD);
  assign pick    = free_r ? free_way_r : victim;
  assign res_way = hit_r ? hit_way_r : (do_fill ? pick : '0);

  // Row written back: zeros while clearing, else aged row with hit or fill applied.
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      if (state_r == S_CLEAR) begin
        wr_row[w] = '0;
      end else if (do_fill && (pick == WAY_W'(w))) begin
        wr_row[w] = {1'b1, cur_tag_r, {AGE_BITS{1'b0}}};
      end else if (hit_r && (hit_way_r == WAY_W'(w))) begin
        wr_row[w] = {rd_row_r[w][ENT_W-1 -: 1 + TAG_W], {AGE_BITS{1'b0}}};
      end else begin
        wr_row[w] = {rd_row_r[w][ENT_W-1 -: 1 + TAG_W], aged_r[w]};
      end
    end
  end

  // Result register, loaded at the end of the fill cycle.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == S_FILL) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FILL) begin
      out_hit_r    <= hit_r;
      out_way_r    <= OUT_WAY_W'(res_way);
      out_filled_r <= do_fill;
      out_set_r    <= OUT_SET_W'(cur_set_r);
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.hit       = out_hit_r;
  assign out_ch.way       = out_way_r;
  assign out_ch.filled    = out_filled_r;
  assign out_ch.set_index = out_set_r;

  assign bstat.clearing = (state_r == S_CLEAR);
  assign bstat.pop      = mem_re;

endmodule
